### hdl/casw_pkg.sv
package casw_pkg;

  localparam int SEQ_W  = 64;
  localparam int LEN_W  = 11;
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 7;

  // request codes on req_type
  localparam logic [1:0] REQ_SEND    = 2'd0;
  localparam logic [1:0] REQ_ACK     = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  // timer commands
  localparam logic [1:0] TMR_NONE       = 2'd0;
  localparam logic [1:0] TMR_START      = 2'd1;
  localparam logic [1:0] TMR_STOP       = 2'd2;
  localparam logic [1:0] TMR_STOP_START = 2'd3;

  // result status
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_BAD_LEN = 2'd2;
  localparam logic [1:0] STS_IGNORED = 2'd3;

  typedef enum logic [2:0] {
    OP_SEND,
    OP_BAD_LEN,
    OP_ACK,
    OP_TIMEOUT,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] ack;
  } cmd_t;

  typedef struct packed {
    logic              tx_valid;
    logic [SEQ_W-1:0]  tx_seq;
    logic [LEN_W-1:0]  tx_len;
    logic [SLOT_W-1:0] tx_slot;
    logic [1:0]        timer_cmd;
    logic [1:0]        status;
    logic [CNT_W-1:0]  outstanding;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK_SCAN,
    ST_TO_SEND
  } state_t;

endpackage

### hdl/casw_front.sv
module casw_front
  import casw_pkg::*;
#(
  parameter int HEADER_LEN     = 16,
  parameter int MAX_PACKET_LEN = 2047
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       req_type,
  input  logic [LEN_W-1:0] packet_len,
  input  logic [SEQ_W-1:0] ack_number,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_take
);

  localparam int CMP_W = 17;

  cmd_t       q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_count;
  cmd_t       classified;
  logic       len_bad;
  logic       push;

  assign in_stall  = (q_count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (q_count != 2'd0);
  assign cmd       = q_mem[rd_ptr];

  always_comb begin
    len_bad = ({{(CMP_W-LEN_W){1'b0}}, packet_len} < CMP_W'(HEADER_LEN)) ||
              ({{(CMP_W-LEN_W){1'b0}}, packet_len} > CMP_W'(MAX_PACKET_LEN));
    classified.len = packet_len;
    classified.ack = ack_number;
    case (req_type)
      REQ_SEND:    classified.op = len_bad ? OP_BAD_LEN : OP_SEND;
      REQ_ACK:     classified.op = OP_ACK;
      REQ_TIMEOUT: classified.op = OP_TIMEOUT;
      default:     classified.op = OP_IGNORE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (cmd_take) rd_ptr <= !rd_ptr;
      q_count <= q_count + {1'b0, push} - {1'b0, cmd_take};
    end
  end

endmodule

### hdl/casw_back.sv
module casw_back
  import casw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int HEADER_LEN  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  output logic out_valid,
  input  logic out_stall,
  output res_t res
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

  function automatic logic [PW-1:0] slot_adv(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  logic [SEQ_W-1:0] seq_mem [QUEUE_DEPTH];
  logic [LEN_W-1:0] len_mem [QUEUE_DEPTH];

  state_t           state, state_next;
  logic [PW-1:0]    head, head_next;
  logic [PW-1:0]    tail, tail_next;
  logic [CW-1:0]    count, count_next;
  logic [SEQ_W-1:0] nseq, nseq_next;
  logic [SEQ_W-1:0] base, base_next;
  logic [SEQ_W-1:0] ack_hold, ack_hold_next;
  logic [SEQ_W-1:0] rd_seq;
  logic [LEN_W-1:0] rd_len;
  logic [SEQ_W-1:0] scan_end;
  logic             mem_we;
  logic             res_load;
  logic             out_free;
  res_t             res_next;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    nseq_next     = nseq;
    base_next     = base;
    ack_hold_next = ack_hold;
    mem_we        = 1'b0;
    cmd_take      = 1'b0;
    res_load      = 1'b0;
    res_next      = '0;
    scan_end      = rd_seq + SEQ_W'(rd_len) - SEQ_W'(HEADER_LEN);

    case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          case (cmd.op)
            OP_SEND: begin
              res_load = 1'b1;
              if (count == FULL_CNT) begin
                res_next.status = STS_FULL;
              end else begin
                mem_we           = 1'b1;
                res_next.tx_valid = 1'b1;
                res_next.tx_seq  = nseq;
                res_next.tx_len  = cmd.len;
                res_next.tx_slot = SLOT_W'(tail);
                res_next.status  = STS_DONE;
                tail_next        = slot_adv(tail);
                count_next       = count + 1'b1;
                if (nseq == base) res_next.timer_cmd = TMR_START;
                nseq_next = nseq + SEQ_W'(cmd.len) - SEQ_W'(HEADER_LEN);
              end
              res_next.outstanding = CNT_W'(count_next);
            end
            OP_BAD_LEN: begin
              res_load             = 1'b1;
              res_next.status      = STS_BAD_LEN;
              res_next.outstanding = CNT_W'(count);
            end
            OP_ACK: begin
              if (cmd.ack > base) begin
                ack_hold_next = cmd.ack;
                state_next    = ST_ACK_SCAN;
              end else begin
                res_load             = 1'b1;
                res_next.status      = STS_IGNORED;
                res_next.outstanding = CNT_W'(count);
              end
            end
            OP_TIMEOUT: begin
              if (count != '0) begin
                state_next = ST_TO_SEND;
              end else begin
                res_load             = 1'b1;
                res_next.status      = STS_IGNORED;
                res_next.outstanding = CNT_W'(count);
              end
            end
            default: begin
              res_load             = 1'b1;
              res_next.status      = STS_IGNORED;
              res_next.outstanding = CNT_W'(count);
            end
          endcase
        end
      end
      ST_ACK_SCAN: begin
        // drop the head entry while the ack covers it wholly
        if (count != '0 && scan_end <= ack_hold) begin
          head_next  = slot_adv(head);
          count_next = count - 1'b1;
        end else if (out_free) begin
          base_next            = ack_hold;
          res_load             = 1'b1;
          res_next.status      = STS_DONE;
          res_next.timer_cmd   = (count != '0) ? TMR_STOP_START : TMR_STOP;
          res_next.outstanding = CNT_W'(count);
          state_next           = ST_IDLE;
        end
      end
      ST_TO_SEND: begin
        if (out_free) begin
          res_load             = 1'b1;
          res_next.tx_valid    = 1'b1;
          res_next.tx_seq      = rd_seq;
          res_next.tx_len      = rd_len;
          res_next.tx_slot     = SLOT_W'(head);
          res_next.timer_cmd   = TMR_START;
          res_next.status      = STS_DONE;
          res_next.outstanding = CNT_W'(count);
          state_next           = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // read port follows the next head so the oldest entry is ready in the cycle after
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seq_mem[tail] <= nseq;
      len_mem[tail] <= cmd.len;
    end
    rd_seq <= seq_mem[head_next];
    rd_len <= len_mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      nseq      <= '0;
      base      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      nseq  <= nseq_next;
      base  <= base_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ack_hold <= ack_hold_next;
    if (res_load) begin
      res <= res_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty queue with head and tail apart");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (state == ST_IDLE) && out_free)
    else $error("command taken while busy or output blocked");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !res_load)
    else $error("held result overwritten");

  a_scan_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACK_SCAN && state_next == ST_ACK_SCAN && out_free)
      |=> (count == $past(count) - 1'b1))
    else $error("ack scan stalled without popping");

endmodule

### hdl/cumulative_ack_sender_window.sv
// Sender window with cumulative acks: a two-entry command queue decouples the
// input from the executor, which owns the (sequence, length) slot memory and
// one registered result. Each item yields exactly one result. Send, rejected
// and ignored items finish in the idle state; a timeout passes through a
// resend state that uses the registered read of the oldest slot; an ack above
// the base passes through a scan state that retires one packet at a time
// through the single read port of the slot memory, then issues its result.
// An idle executor with a free output takes a command in the cycle after its
// input transfer, and the result is offered once its last executor cycle ends.
// Slot numbers and the outstanding count on the ports are the low bits of the
// internal pointer and count.
module cumulative_ack_sender_window
  import casw_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 64,
  parameter int HEADER_LEN     = 16,
  parameter int MAX_PACKET_LEN = 2047
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [LEN_W-1:0]  packet_len,
  input  logic [SEQ_W-1:0]  ack_number,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              tx_valid,
  output logic [SEQ_W-1:0]  tx_seq,
  output logic [LEN_W-1:0]  tx_len,
  output logic [SLOT_W-1:0] tx_slot,
  output logic [1:0]        timer_cmd,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  outstanding
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  res_t res;

  casw_front #(
    .HEADER_LEN     (HEADER_LEN),
    .MAX_PACKET_LEN (MAX_PACKET_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .packet_len (packet_len),
    .ack_number (ack_number),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  casw_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HEADER_LEN  (HEADER_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign tx_valid    = res.tx_valid;
  assign tx_seq      = res.tx_seq;
  assign tx_len      = res.tx_len;
  assign tx_slot     = res.tx_slot;
  assign timer_cmd   = res.timer_cmd;
  assign status      = res.status;
  assign outstanding = res.outstanding;

endmodule

### tb/tb_cumulative_ack_sender_window.sv
`timescale 1ns / 100ps

module tb_cumulative_ack_sender_window;
  import casw_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 1020;
  localparam int TAIL_STEADY  = 150;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AFTER   = 400;
  localparam int STUCK_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;

  // Window model: predicts one result per accepted request, checks them in order.
  class window_scoreboard;
    localparam int QDEPTH = 64;
    localparam int HDR    = 16;
    localparam int MAXLEN = 2047;

    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] window_base;
    logic [SEQ_W-1:0] slot_seq [QDEPTH];
    logic [LEN_W-1:0] slot_len [QDEPTH];
    int oldest;
    int fill_slot;
    int in_flight;
    res_t expected_q[$];
    int errors;
    int results_seen;

    function new();
      next_seq = '0;
      window_base = '0;
      oldest = 0;
      fill_slot = 0;
      in_flight = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    // byte just past the k-th queued packet, counted from the oldest
    function logic [SEQ_W-1:0] packet_end(int k);
      int idx;
      idx = (oldest + k) % QDEPTH;
      return slot_seq[idx] + SEQ_W'(slot_len[idx]) - SEQ_W'(HDR);
    endfunction

    function void note_request(logic [1:0] rq, logic [LEN_W-1:0] ln, logic [SEQ_W-1:0] ak);
      res_t r;
      r = '0;
      r.timer_cmd = TMR_NONE;
      r.status = STS_DONE;
      case (rq)
        REQ_SEND: begin
          if (ln < HDR || ln > MAXLEN) begin
            r.status = STS_BAD_LEN;
          end else if (in_flight >= QDEPTH) begin
            r.status = STS_FULL;
          end else begin
            r.tx_valid = 1'b1;
            r.tx_seq = next_seq;
            r.tx_len = ln;
            r.tx_slot = SLOT_W'(fill_slot);
            slot_seq[fill_slot] = next_seq;
            slot_len[fill_slot] = ln;
            fill_slot = (fill_slot + 1) % QDEPTH;
            in_flight++;
            if (next_seq == window_base) r.timer_cmd = TMR_START;
            next_seq = next_seq + SEQ_W'(ln) - SEQ_W'(HDR);
          end
        end
        REQ_ACK: begin
          if (ak > window_base) begin
            // retire every packet the ack covers completely
            while (in_flight > 0 && packet_end(0) <= ak) begin
              oldest = (oldest + 1) % QDEPTH;
              in_flight--;
            end
            window_base = ak;
            r.timer_cmd = (in_flight > 0) ? TMR_STOP_START : TMR_STOP;
          end else begin
            r.status = STS_IGNORED;
          end
        end
        REQ_TIMEOUT: begin
          if (in_flight > 0) begin
            r.tx_valid = 1'b1;
            r.tx_seq = slot_seq[oldest];
            r.tx_len = slot_len[oldest];
            r.tx_slot = SLOT_W'(oldest);
            r.timer_cmd = TMR_START;
          end else begin
            r.status = STS_IGNORED;
          end
        end
        default: r.status = STS_IGNORED;
      endcase
      r.outstanding = CNT_W'(in_flight);
      expected_q.push_back(r);
    endfunction

    function void report_mismatch(string what, logic [SEQ_W-1:0] got, logic [SEQ_W-1:0] want);
      if (errors < 40)
        $display("%0t: result %0d, %s: got %0h, want %0h", $time, results_seen, what, got, want);
      errors++;
    endfunction

    function void check_result(res_t got);
      res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.tx_valid !== want.tx_valid) report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
      if (got.tx_seq !== want.tx_seq) report_mismatch("tx_seq", got.tx_seq, want.tx_seq);
      if (got.tx_len !== want.tx_len) report_mismatch("tx_len", got.tx_len, want.tx_len);
      if (got.tx_slot !== want.tx_slot) report_mismatch("tx_slot", got.tx_slot, want.tx_slot);
      if (got.timer_cmd !== want.timer_cmd)
        report_mismatch("timer_cmd", got.timer_cmd, want.timer_cmd);
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.outstanding !== want.outstanding)
        report_mismatch("outstanding", got.outstanding, want.outstanding);
    endfunction
  endclass

  localparam int HDR    = window_scoreboard::HDR;
  localparam int MAXLEN = window_scoreboard::MAXLEN;
  localparam int QDEPTH = window_scoreboard::QDEPTH;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        req_type;
  logic [LEN_W-1:0]  packet_len;
  logic [SEQ_W-1:0]  ack_number;
  logic              out_valid;
  logic              out_stall;
  logic              tx_valid;
  logic [SEQ_W-1:0]  tx_seq;
  logic [LEN_W-1:0]  tx_len;
  logic [SLOT_W-1:0] tx_slot;
  logic [1:0]        timer_cmd;
  logic [1:0]        status;
  logic [CNT_W-1:0]  outstanding;
  res_t              seen;

  window_scoreboard sb;
  logic sender_idles = 1'b1;
  logic steady_tail = 1'b0;
  int   fill_left = 0;
  int   stuck_cycles = 0;

  cumulative_ack_sender_window u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .packet_len (packet_len),
    .ack_number (ack_number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tx_valid   (tx_valid),
    .tx_seq     (tx_seq),
    .tx_len     (tx_len),
    .tx_slot    (tx_slot),
    .timer_cmd  (timer_cmd),
    .status     (status),
    .outstanding(outstanding)
  );

  assign seen = {tx_valid, tx_seq, tx_len, tx_slot, timer_cmd, status, outstanding};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0: return LEN_W'(HDR);
      1: return LEN_W'(MAXLEN);
      2, 3: return LEN_W'($urandom_range(HDR, MAXLEN));
      default: return LEN_W'($urandom_range(HDR, HDR + 200));
    endcase
  endfunction

  // Mostly well-formed traffic built from the current window, plus some noise.
  task automatic make_request(output logic [1:0] rq, output logic [LEN_W-1:0] ln,
                              output logic [SEQ_W-1:0] ak);
    int roll;
    int k;
    rq = REQ_SEND;
    ln = LEN_W'($urandom);
    ak = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (fill_left > 0) begin
      fill_left--;
      ln = pick_len();
    end else if (roll < 3) begin
      // run into a full queue
      fill_left = QDEPTH - sb.in_flight + $urandom_range(1, 3);
      ln = pick_len();
    end else if (roll < 45) begin
      ln = pick_len();
    end else if (roll < 72) begin
      rq = REQ_ACK;
      if (sb.in_flight > 0 && $urandom_range(0, 7) != 0) begin
        k = $urandom_range(0, sb.in_flight - 1);
        ak = sb.packet_end(k);
        if ($urandom_range(0, 3) == 0) ak = ak - 1'b1;
      end else begin
        ak = sb.next_seq;
      end
    end else if (roll < 82) begin
      rq = REQ_TIMEOUT;
    end else if (roll < 87) begin
      ln = LEN_W'($urandom_range(0, HDR - 1));
    end else if (roll < 92) begin
      rq = REQ_ACK;
      ak = (sb.window_base > 5) ? sb.window_base - SEQ_W'($urandom_range(0, 5))
                                : sb.window_base;
    end else if (roll < 96) begin
      rq = REQ_UNKNOWN;
    end else begin
      // ack past everything sent so far
      rq = REQ_ACK;
      ak = sb.next_seq + SEQ_W'($urandom_range(1, 3000));
    end
  endtask

  task automatic drive_request(input logic [1:0] rq, input logic [LEN_W-1:0] ln,
                               input logic [SEQ_W-1:0] ak);
    int gap;
    gap = 0;
    if (sender_idles && !steady_tail && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      req_type <= 2'($urandom);
      packet_len <= LEN_W'($urandom);
      ack_number <= {$urandom, $urandom};
    end
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= rq;
    packet_len <= ln;
    ack_number <= ak;
    do @(posedge clk); while (in_stall);
    sb.note_request(rq, ln, ak);
  endtask

  // receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    int hold_left;
    int burst_left;
    int phase_left;
    logic idles_on;
    logic held;
    out_stall = 1'b0;
    hold_left = 0;
    burst_left = 0;
    phase_left = 0;
    idles_on = 1'b1;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        phase_left = $urandom_range(50, 300);
        idles_on = ($urandom_range(0, 3) != 0);
      end
      phase_left--;
      if (!held && sb.results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idles_on && !steady_tail && $urandom_range(0, 99) < 20) begin
        burst_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) sb.check_result(seen);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles", STUCK_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [1:0]       rq;
    logic [LEN_W-1:0] ln;
    logic [SEQ_W-1:0] ak;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_SEND;
    packet_len = '0;
    ack_number = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // opening: corner cases on a fresh window
    drive_request(REQ_TIMEOUT, LEN_W'($urandom), {$urandom, $urandom}); // nothing to resend
    drive_request(REQ_ACK, LEN_W'($urandom), '0);                        // stale ack
    drive_request(REQ_UNKNOWN, '1, '1);
    drive_request(REQ_SEND, '0, '0);                                     // short packets
    drive_request(REQ_SEND, LEN_W'(HDR - 1), {$urandom, $urandom});
    drive_request(REQ_SEND, LEN_W'(HDR), {$urandom, $urandom});          // empty payload
    drive_request(REQ_SEND, LEN_W'(HDR + 1), {$urandom, $urandom});
    drive_request(REQ_SEND, LEN_W'(MAXLEN), {$urandom, $urandom});
    drive_request(REQ_SEND, LEN_W'(HDR), {$urandom, $urandom});
    drive_request(REQ_TIMEOUT, '0, '0);
    drive_request(REQ_ACK, '0, sb.packet_end(1) - 1'b1);                 // ack equal to the base, ignored
    drive_request(REQ_ACK, '0, sb.window_base);                          // repeated ack
    drive_request(REQ_ACK, '0, sb.packet_end(1));
    drive_request(REQ_TIMEOUT, '0, '0);
    drive_request(REQ_ACK, '0, sb.next_seq);                             // clears the window
    drive_request(REQ_TIMEOUT, '0, '0);
    drive_request(REQ_SEND, 11'd100, '0);
    drive_request(REQ_ACK, '0, sb.next_seq + 64'd1000);                  // beyond sent data
    drive_request(REQ_SEND, 11'd50, '0);
    drive_request(REQ_ACK, '0, sb.window_base + 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) sender_idles = ($urandom_range(0, 3) != 0);
      if (n == RANDOM_ITEMS - TAIL_STEADY) steady_tail = 1'b1;
      make_request(rq, ln, ak);
      drive_request(rq, ln, ak);
    end

    // push the base into the upper half of the sequence space
    drive_request(REQ_ACK, LEN_W'($urandom), {1'b1, 31'($urandom), $urandom});
    repeat (3) drive_request(REQ_SEND, pick_len(), {$urandom, $urandom});
    drive_request(REQ_TIMEOUT, LEN_W'($urandom), {$urandom, $urandom});
    drive_request(REQ_ACK, LEN_W'($urandom), {$urandom, $urandom});
    drive_request(REQ_ACK, LEN_W'($urandom), '1);
    drive_request(REQ_SEND, 11'd300, {$urandom, $urandom});
    drive_request(REQ_TIMEOUT, LEN_W'($urandom), {$urandom, $urandom});
    drive_request(REQ_ACK, LEN_W'($urandom), {$urandom, $urandom});
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
hdl/casw_pkg.sv
hdl/casw_front.sv
hdl/casw_back.sv
hdl/cumulative_ack_sender_window.sv
tb/tb_cumulative_ack_sender_window.sv
